### hw/rtl/kplp_pkg.sv
// shared types, codes and helper function of the key press classifier
package kplp_pkg;

	// width of the held-time tick counter
	localparam int TICK_WIDTH = 16;
	// width of the long-press threshold register
	localparam int THR_WIDTH = 16;
	// compare width for counter against threshold
	localparam int CMP_WIDTH = (TICK_WIDTH > THR_WIDTH) ? TICK_WIDTH : THR_WIDTH;

	// register indexes of the configuration port
	localparam logic [1:0] REG_IDLE_LEVEL = 2'd0;
	localparam logic [1:0] REG_LONG_TICKS = 2'd1;
	localparam logic [1:0] REG_X_COUNT    = 2'd2;
	localparam logic [1:0] REG_Y_COUNT    = 2'd3;

	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_SET    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_LONG    = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_LONG    = 2'd2
	} phase_t;

	// one result item
	typedef struct packed {
		event_t     event_code;
		logic [7:0] cursor_x;
		logic [7:0] cursor_y;
		logic       press_seen;
		logic       release_seen;
		logic       long_seen;
	} result_t;

	// cursor plus one, wrapping to one once it passes the count (nine-bit compare)
	function automatic logic [7:0] advance(input logic [7:0] pos, input logic [7:0] count);
		logic [8:0] nxt;
		nxt = {1'b0, pos} + 9'd1;
		if (nxt > {1'b0, count}) begin
			return 8'd1;
		end
		return nxt[7:0];
	endfunction

endpackage

### hw/rtl/kplp_out_buf.sv
// two-entry output register with skid stage for result items
module kplp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kplp_pkg::result_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output kplp_pkg::result_t out_data
);

	logic              main_valid_q;
	logic              skid_valid_q;
	kplp_pkg::result_t main_q;
	kplp_pkg::result_t skid_q;
	logic              push;
	logic              pop;

	// take a new result whenever the skid slot is free
	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign push      = in_valid && in_ready;
	assign pop       = main_valid_q && out_ready;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without main entry");

	a_main_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(main_valid_q && !out_ready) |=> (main_valid_q && $stable(main_q)))
		else $error("stalled result changed");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !pop) |=> skid_valid_q)
		else $error("skid entry lost while stalled");

endmodule

### hw/rtl/key_press_long_press_menu_cursor.sv
// key press classifier: short/long press detection, sticky flags, menu cursor
// a result is registered in the output buffer before it reaches the master side
// throughput: one item per cycle unless stalled; state registered once per item
// a two-entry output buffer keeps accepting one more item while output stalls
// reset (arst_n low, asynchronous): phase idle, counter 0, cursors 1, flags 0,
// registers idle_level 1, long_press_ticks 100, menu counts 7, output empty
module key_press_long_press_menu_cursor (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] key_level, [3:1] clear_mask, [11:4] set_x, [19:12] set_y, [23:20] zero
	input  logic [23:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] cursor_x_out, [15:8] cursor_y_out, [16] press_seen, [17] release_seen,
	// [18] long_seen, [23:19] zero
	output logic [23:0] m_tdata,
	// [1:0] event_code
	output logic [1:0]  m_tuser
);

	logic                          idle_level_q;
	logic [kplp_pkg::THR_WIDTH-1:0] long_ticks_q;
	logic [7:0]                    x_count_q;
	logic [7:0]                    y_count_q;

	kplp_pkg::phase_t               phase_q;
	kplp_pkg::phase_t               phase_d;
	logic [kplp_pkg::TICK_WIDTH-1:0] held_q;
	logic [kplp_pkg::TICK_WIDTH-1:0] held_d;
	logic [7:0]                     cursor_x_q;
	logic [7:0]                     cursor_x_d;
	logic [7:0]                     cursor_y_q;
	logic [7:0]                     cursor_y_d;
	logic                           press_q;
	logic                           press_d;
	logic                           release_q;
	logic                           release_d;
	logic                           long_q;
	logic                           long_d;
	kplp_pkg::event_t               event_d;

	kplp_pkg::action_t act;
	logic              key_level;
	logic [2:0]        clear_mask;
	logic [7:0]        set_x;
	logic [7:0]        set_y;
	logic              at_idle;
	logic              long_reached;
	logic              accept;
	logic              buf_ready;
	kplp_pkg::result_t res;
	kplp_pkg::result_t out_res;

	// unpack input fields
	assign act        = kplp_pkg::action_t'(s_tuser);
	assign key_level  = s_tdata[0];
	assign clear_mask = s_tdata[3:1];
	assign set_x      = s_tdata[11:4];
	assign set_y      = s_tdata[19:12];

	assign s_tready = buf_ready;
	assign accept   = s_tvalid && buf_ready;
	assign at_idle  = (key_level == idle_level_q);
	assign long_reached = (kplp_pkg::CMP_WIDTH'(held_q) >= kplp_pkg::CMP_WIDTH'(long_ticks_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q <= 1'b1;
			long_ticks_q <= kplp_pkg::THR_WIDTH'(100);
			x_count_q    <= 8'd7;
			y_count_q    <= 8'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				kplp_pkg::REG_IDLE_LEVEL: idle_level_q <= cfg_data[0];
				kplp_pkg::REG_LONG_TICKS: long_ticks_q <= cfg_data[kplp_pkg::THR_WIDTH-1:0];
				kplp_pkg::REG_X_COUNT:    x_count_q    <= cfg_data[7:0];
				kplp_pkg::REG_Y_COUNT:    y_count_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (act == kplp_pkg::ACT_SAMPLE) begin
			case (phase_q)
				kplp_pkg::PH_PRESSED: begin
					if (at_idle) begin
						phase_d = kplp_pkg::PH_IDLE;
					end else if (long_reached) begin
						phase_d = kplp_pkg::PH_LONG;
					end
				end
				kplp_pkg::PH_LONG: begin
					if (at_idle) begin
						phase_d = kplp_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = at_idle ? kplp_pkg::PH_IDLE : kplp_pkg::PH_PRESSED;
				end
			endcase
		end
	end

	// event, counter, cursors and flags
	always_comb begin
		event_d    = kplp_pkg::EV_NONE;
		held_d     = held_q;
		cursor_x_d = cursor_x_q;
		cursor_y_d = cursor_y_q;
		press_d    = press_q;
		release_d  = release_q;
		long_d     = long_q;
		case (act)
			kplp_pkg::ACT_TICK: begin
				if (held_q != '1) begin
					held_d = held_q + kplp_pkg::TICK_WIDTH'(1);
				end
			end
			kplp_pkg::ACT_SAMPLE: begin
				case (phase_q)
					kplp_pkg::PH_PRESSED: begin
						if (at_idle) begin
							event_d    = kplp_pkg::EV_RELEASE;
							release_d  = 1'b1;
							cursor_x_d = kplp_pkg::advance(cursor_x_q, x_count_q);
						end else if (long_reached) begin
							event_d    = kplp_pkg::EV_LONG;
							long_d     = 1'b1;
							cursor_y_d = kplp_pkg::advance(cursor_y_q, y_count_q);
						end
					end
					kplp_pkg::PH_LONG: ;
					default: begin
						if (!at_idle) begin
							event_d = kplp_pkg::EV_PRESS;
							held_d  = '0;
							press_d = 1'b1;
						end
					end
				endcase
			end
			kplp_pkg::ACT_CLEAR: begin
				if (clear_mask[0]) press_d   = 1'b0;
				if (clear_mask[1]) release_d = 1'b0;
				if (clear_mask[2]) long_d    = 1'b0;
			end
			default: begin
				cursor_x_d = set_x;
				cursor_y_d = set_y;
			end
		endcase
	end

	// classifier state, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= kplp_pkg::PH_IDLE;
			held_q     <= '0;
			cursor_x_q <= 8'd1;
			cursor_y_q <= 8'd1;
			press_q    <= 1'b0;
			release_q  <= 1'b0;
			long_q     <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			held_q     <= held_d;
			cursor_x_q <= cursor_x_d;
			cursor_y_q <= cursor_y_d;
			press_q    <= press_d;
			release_q  <= release_d;
			long_q     <= long_d;
		end
	end

	// result item for this transfer
	always_comb begin
		res.event_code   = event_d;
		res.cursor_x     = cursor_x_d;
		res.cursor_y     = cursor_y_d;
		res.press_seen   = press_d;
		res.release_seen = release_d;
		res.long_seen    = long_d;
	end

	kplp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (buf_ready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// pack result fields
	assign m_tuser = out_res.event_code;
	assign m_tdata = {5'b0, out_res.long_seen, out_res.release_seen, out_res.press_seen,
		out_res.cursor_y, out_res.cursor_x};

	a_release_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && event_d == kplp_pkg::EV_RELEASE) |=> (phase_q == kplp_pkg::PH_IDLE))
		else $error("release did not return to idle");

	a_press_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && event_d == kplp_pkg::EV_PRESS) |=>
		(held_q == '0 && phase_q == kplp_pkg::PH_PRESSED))
		else $error("press did not restart the hold counter");

	a_advance_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (event_d == kplp_pkg::EV_RELEASE || event_d == kplp_pkg::EV_LONG)) |=>
		(cursor_x_q != 8'd0 && cursor_y_q != 8'd0 ||
		 $past(event_d) == kplp_pkg::EV_RELEASE && cursor_x_q != 8'd0 ||
		 $past(event_d) == kplp_pkg::EV_LONG && cursor_y_q != 8'd0))
		else $error("cursor advance produced zero");

endmodule

### sim/tb_top.sv
// testbench of the key press classifier: stream driver, result monitor and state predictor
module tb_top;
	import kplp_pkg::*;

	// one input transfer before packing
	typedef struct packed {
		action_t    action;
		logic       key_level;
		logic [2:0] clear_mask;
		logic [7:0] set_x;
		logic [7:0] set_y;
	} key_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	// [0] key_level, [3:1] clear_mask, [11:4] set_x, [19:12] set_y, [23:20] zero
	logic [23:0] s_tdata;
	// [1:0] action
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [7:0] cursor_x_out, [15:8] cursor_y_out, [16] press_seen, [17] release_seen,
	// [18] long_seen, [23:19] zero
	logic [23:0] m_tdata;
	// [1:0] event_code
	logic [1:0]  m_tuser;

	key_press_long_press_menu_cursor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// predicted configuration
	logic                  idle_lvl;
	logic [15:0]           thr;
	logic [7:0]            x_cnt;
	logic [7:0]            y_cnt;
	// predicted classifier state
	phase_t                key_phase_m;
	logic [TICK_WIDTH-1:0] held;
	logic [7:0]            cur_x;
	logic [7:0]            cur_y;
	logic                  press_f;
	logic                  release_f;
	logic                  long_f;

	key_item_t pending_items[$];
	result_t   expected_results[$];
	key_item_t cur_item;

	bit steady;
	int errors;
	int n_results;
	int n_press;
	int n_release;
	int n_long;
	int n_settings;

	always #2 clk = ~clk;

	// random back-pressure and gaps, off during steady stretches
	function automatic bit hold_off();
		return !steady && ($urandom_range(99) < 38);
	endfunction

	// next menu position, nine-bit compare against the count
	function automatic logic [7:0] step_cursor(logic [7:0] pos, logic [7:0] count);
		logic [8:0] nxt;
		nxt = {1'b0, pos} + 9'd1;
		return (nxt > {1'b0, count}) ? 8'd1 : nxt[7:0];
	endfunction

	// update the predicted state with one item and return the result it gives
	function automatic result_t classify_item(key_item_t it);
		result_t r;
		logic    at_rest;
		at_rest = (it.key_level == idle_lvl);
		r.event_code = EV_NONE;
		case (it.action)
			ACT_TICK: begin
				if (held != '1)
					held = held + TICK_WIDTH'(1);
			end
			ACT_SAMPLE: begin
				case (key_phase_m)
					PH_PRESSED: begin
						if (at_rest) begin
							key_phase_m = PH_IDLE;
							r.event_code = EV_RELEASE;
							release_f = 1'b1;
							cur_x = step_cursor(cur_x, x_cnt);
						end else if (held >= thr) begin
							key_phase_m = PH_LONG;
							r.event_code = EV_LONG;
							long_f = 1'b1;
							cur_y = step_cursor(cur_y, y_cnt);
						end
					end
					PH_LONG: begin
						if (at_rest)
							key_phase_m = PH_IDLE;
					end
					default: begin
						key_phase_m = PH_IDLE;
						if (!at_rest) begin
							key_phase_m = PH_PRESSED;
							held = '0;
							press_f = 1'b1;
							r.event_code = EV_PRESS;
						end
					end
				endcase
			end
			ACT_CLEAR: begin
				if (it.clear_mask[0]) press_f = 1'b0;
				if (it.clear_mask[1]) release_f = 1'b0;
				if (it.clear_mask[2]) long_f = 1'b0;
			end
			default: begin
				cur_x = it.set_x;
				cur_y = it.set_y;
			end
		endcase
		r.cursor_x = cur_x;
		r.cursor_y = cur_y;
		r.press_seen = press_f;
		r.release_seen = release_f;
		r.long_seen = long_f;
		return r;
	endfunction

	function automatic key_item_t mk_item(action_t a, logic k, logic [2:0] m,
			logic [7:0] x, logic [7:0] y);
		key_item_t it;
		it.action = a;
		it.key_level = k;
		it.clear_mask = m;
		it.set_x = x;
		it.set_y = y;
		return it;
	endfunction

	function automatic void queue_sample(logic k);
		pending_items.push_back(mk_item(ACT_SAMPLE, k, 3'd0, 8'd0, 8'd0));
	endfunction

	function automatic void queue_tick();
		pending_items.push_back(mk_item(ACT_TICK, 1'b0, 3'd0, 8'd0, 8'd0));
	endfunction

	// mostly full press gestures with random hold times, the rest noise
	function automatic void queue_random(int n);
		int        target;
		int        k;
		int        cap;
		key_item_t it;
		target = pending_items.size() + n;
		while (pending_items.size() < target) begin
			if ($urandom_range(99) < 75) begin
				cap = (thr < 40) ? int'(thr) + 3 : 40;
				k = $urandom_range(0, cap);
				queue_sample(!idle_lvl);
				for (int i = 0; i < k; i++) begin
					queue_tick();
					if ($urandom_range(2) == 0)
						queue_sample(!idle_lvl);
				end
				if ($urandom_range(3) == 0)
					queue_sample(!idle_lvl);
				if ($urandom_range(9) == 0)
					pending_items.push_back(mk_item(ACT_CLEAR, 1'($urandom),
						3'($urandom), 8'($urandom), 8'($urandom)));
				queue_sample(idle_lvl);
			end else begin
				it = mk_item(action_t'($urandom_range(3)), 1'($urandom), 3'($urandom),
					8'($urandom), 8'($urandom));
				pending_items.push_back(it);
			end
		end
	endfunction

	// register write on the configuration port, mirrored into the predictor
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_IDLE_LEVEL: idle_lvl = val[0];
			REG_LONG_TICKS: thr = val;
			REG_X_COUNT:    x_cnt = val[7:0];
			default:        y_cnt = val[7:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(logic idle, logic [15:0] t, logic [7:0] xc, logic [7:0] yc);
		write_reg(REG_IDLE_LEVEL, {15'd0, idle});
		write_reg(REG_LONG_TICKS, t);
		write_reg(REG_X_COUNT, {8'd0, xc});
		write_reg(REG_Y_COUNT, {8'd0, yc});
		n_settings++;
	endtask

	// wait until every queued item is sent and every result has come back
	task automatic drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// stream driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(classify_item(cur_item));
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && !hold_off()) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'd0, cur_item.set_y, cur_item.set_x,
						cur_item.clear_mask, cur_item.key_level};
					s_tuser <= cur_item.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic report(string field, int want, int got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		errors++;
	endtask

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$display("%0t: result transfer with nothing expected, actual %h/%h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					case (want.event_code)
						EV_PRESS:   n_press++;
						EV_RELEASE: n_release++;
						EV_LONG:    n_long++;
						default:    ;
					endcase
					if (m_tuser !== want.event_code)
						report("event_code", want.event_code, m_tuser);
					if (m_tdata[7:0] !== want.cursor_x)
						report("cursor_x_out", want.cursor_x, m_tdata[7:0]);
					if (m_tdata[15:8] !== want.cursor_y)
						report("cursor_y_out", want.cursor_y, m_tdata[15:8]);
					if (m_tdata[16] !== want.press_seen)
						report("press_seen", want.press_seen, m_tdata[16]);
					if (m_tdata[17] !== want.release_seen)
						report("release_seen", want.release_seen, m_tdata[17]);
					if (m_tdata[18] !== want.long_seen)
						report("long_seen", want.long_seen, m_tdata[18]);
				end
			end
			m_tready <= !hold_off();
		end
	end

	// stimulus sequence
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IDLE_LEVEL;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_TICK;
		m_tready = 1'b0;
		steady = 1'b0;
		errors = 0;
		n_results = 0;
		n_press = 0;
		n_release = 0;
		n_long = 0;
		n_settings = 1;
		// reset values of the predictor
		idle_lvl = 1'b1;
		thr = 16'd100;
		x_cnt = 8'd7;
		y_cnt = 8'd7;
		key_phase_m = PH_IDLE;
		held = '0;
		cur_x = 8'd1;
		cur_y = 8'd1;
		press_f = 1'b0;
		release_f = 1'b0;
		long_f = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: short and long gestures on reset counts, flag clears, cursor wrap
		write_reg(REG_LONG_TICKS, 16'd3);
		queue_sample(1'b1);
		queue_sample(1'b0);
		queue_sample(1'b0);
		queue_tick();
		queue_tick();
		queue_sample(1'b0);
		queue_tick();
		queue_sample(1'b0);
		queue_sample(1'b0);
		queue_tick();
		queue_sample(1'b1);
		queue_sample(1'b1);
		queue_sample(1'b0);
		queue_tick();
		queue_sample(1'b1);
		pending_items.push_back(mk_item(ACT_CLEAR, 1'b0, 3'd0, 8'd0, 8'd0));
		pending_items.push_back(mk_item(ACT_CLEAR, 1'b1, 3'd1, 8'd0, 8'd0));
		pending_items.push_back(mk_item(ACT_CLEAR, 1'b0, 3'd2, 8'd0, 8'd0));
		pending_items.push_back(mk_item(ACT_CLEAR, 1'b0, 3'd4, 8'd0, 8'd0));
		pending_items.push_back(mk_item(ACT_CLEAR, 1'b0, 3'd7, 8'd0, 8'd0));
		pending_items.push_back(mk_item(ACT_SET, 1'b0, 3'd7, 8'd255, 8'd255));
		queue_sample(1'b0);
		queue_sample(1'b1);
		pending_items.push_back(mk_item(ACT_SET, 1'b1, 3'd0, 8'd0, 8'd0));
		queue_tick();
		drain();

		// lowest counts and threshold, active-high key
		apply_setting(1'b0, 16'd1, 8'd1, 8'd1);
		queue_random(400);
		drain();

		// highest counts, cursors parked just below the wrap
		apply_setting(1'b1, 16'($urandom_range(2, 20)), 8'd255, 8'd255);
		pending_items.push_back(mk_item(ACT_SET, 1'b0, 3'd0, 8'd254, 8'd254));
		queue_random(400);
		drain();

		// no idling on either side
		steady = 1'b1;
		apply_setting(1'b0, 16'($urandom_range(1, 30)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)));
		queue_random(200);
		drain();
		queue_random(200);
		drain();

		// highest threshold: a short hold gives only press and release
		apply_setting(1'b1, 16'hFFFF, 8'd3, 8'd200);
		queue_sample(1'b0);
		for (int i = 0; i < 20; i++)
			queue_tick();
		queue_sample(1'b0);
		queue_tick();
		queue_sample(1'b1);
		drain();
		steady = 1'b0;
		queue_random(100);
		drain();

		// random settings
		for (int p = 0; p < 3; p++) begin
			apply_setting(1'($urandom), 16'($urandom_range(1, 16)),
				8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
			queue_random(170);
			drain();
		end

		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_results.size());
			errors++;
		end
		$display("checked %0d result transfers under %0d register settings", n_results,
			n_settings);
		$display("seen %0d presses, %0d short releases, %0d long presses", n_press,
			n_release, n_long);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

endmodule

### key_press_long_press_menu_cursor.f
hw/rtl/kplp_pkg.sv
hw/rtl/kplp_out_buf.sv
hw/rtl/key_press_long_press_menu_cursor.sv
sim/tb_top.sv
